// ----- rtl/wavp_pkg.sv -----
// wavp_pkg: shared types, constants and helpers for the wav header / pcm16 parser
// depends on nothing; used by wavp_parse and wav_header_and_pcm16_parser_unit
package wavp_pkg;

  // header layout
  localparam int unsigned HDR_BYTES = 44;
  localparam int unsigned RIFF_POS  = 0;
  localparam int unsigned WAVE_POS  = 8;
  localparam int unsigned CHAN_POS  = 22;
  localparam int unsigned RATE_POS  = 24;
  localparam int unsigned DEPTH_POS = 34;
  localparam int unsigned SIZE_POS  = 40;

  // magic tags, byte 0 in the low lane
  localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
  localparam logic [31:0] WAVE_TAG = 32'h4556_4157;

  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_SAMPLE   = 3'd1,
    KIND_SHORT    = 3'd2,
    KIND_BAD_RIFF = 3'd3,
    KIND_BAD_WAVE = 3'd4,
    KIND_END      = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_SAMPLES = 2'd1,
    PH_SKIP    = 2'd2
  } phase_t;

  // one result word plus its valid flag
  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic signed [15:0] sample;
    logic [15:0]        channels;
    logic [31:0]        sample_rate;
    logic [15:0]        bit_depth;
    logic [31:0]        data_length;
    logic               last;
  } res_t;

  // byte of a little-endian tag at the given lane
  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] lane);
    tag_byte = tag[{lane, 3'b000} +: 8];
  endfunction

  // merge a byte into a little-endian field at the given lane
  function automatic logic [31:0] put_lane(input logic [31:0] hold, input logic [7:0] b,
                                           input logic [1:0] lane);
    put_lane = hold | ({24'h0, b} << {lane, 3'b000});
  endfunction

endpackage

// ----- rtl/wavp_if.sv -----
// wavp_in_if / wavp_out_if: valid-ready channels of the wav parser
// depends on nothing
interface wavp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wavp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [15:0] sample;
  logic [15:0]        channels;
  logic [31:0]        sample_rate;
  logic [15:0]        bit_depth;
  logic [31:0]        data_length;
  logic               last;

  modport source (output valid, output kind, output sample, output channels,
                  output sample_rate, output bit_depth, output data_length,
                  output last, input ready);
  modport sink   (input valid, input kind, input sample, input channels,
                  input sample_rate, input bit_depth, input data_length,
                  input last, output ready);
endinterface

// ----- rtl/wav_header_and_pcm16_parser_unit.sv -----
// wav_header_and_pcm16_parser_unit: top level of the wav header / pcm16 parser
// depends on wavp_pkg, wavp_if (wavp_in_if, wavp_out_if) and wavp_parse
//
//   channel   dir   word                               handshake
//   in_ch     in    data_byte[7:0], last_byte          valid / ready
//   out_ch    out   kind, sample, header fields, last  valid / ready
//
// one byte per cycle sustained while out_ch.ready is high; an accepted byte waits in the
// input register, and the parser logic writes its result into the result register
// rst_n is synchronous, active low, and puts the parser at the start of a file
// a stalled result holds the result register; the input register keeps one more
// byte, so in_ch.ready drops only while both are full and out_ch.ready is low
module wav_header_and_pcm16_parser_unit (
  input  logic              clk,
  input  logic              rst_n,
  wavp_in_if.sink           in_ch,
  wavp_out_if.source        out_ch
);

  // input register
  logic       s1_vld_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // result register
  logic           out_vld_r;
  wavp_pkg::res_t out_res_r;

  wavp_pkg::res_t res;
  logic           out_free;
  logic           advance;

  // result register can take a new word this cycle
  assign out_free = !out_vld_r || out_ch.ready;
  // the byte in the input register is processed this cycle
  assign advance  = s1_vld_r && out_free;

  assign in_ch.ready = !s1_vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      s1_byte_r <= in_ch.data_byte;
      s1_last_r <= in_ch.last_byte;
    end
  end

  wavp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .res       (res)
  );

  // bytes that cause no result just leave the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= advance && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.kind        = out_res_r.kind;
  assign out_ch.sample      = out_res_r.sample;
  assign out_ch.channels    = out_res_r.channels;
  assign out_ch.sample_rate = out_res_r.sample_rate;
  assign out_ch.bit_depth   = out_res_r.bit_depth;
  assign out_ch.data_length = out_res_r.data_length;
  assign out_ch.last        = out_res_r.last;

  // a byte waiting behind a stalled result is neither lost nor changed
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !out_free |=> s1_vld_r && $stable(s1_byte_r) && $stable(s1_last_r))
    else $error("input register lost its byte during an output stall");

  // short file and odd trailing byte always close the file
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.kind == wavp_pkg::KIND_SHORT ||
                     out_ch.kind == wavp_pkg::KIND_END) |-> out_ch.last)
    else $error("short or end result without last");

  // header fields only on a good header, sample only on a sample word
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind != wavp_pkg::KIND_HEADER |->
      out_ch.channels == '0 && out_ch.sample_rate == '0 &&
      out_ch.bit_depth == '0 && out_ch.data_length == '0)
    else $error("header fields set on a non-header result");

  a_zero_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind != wavp_pkg::KIND_SAMPLE |-> out_ch.sample == '0)
    else $error("sample set on a non-sample result");

endmodule

// ----- rtl/wavp_parse.sv -----
// wavp_parse: parser state and per-byte result logic
// depends on wavp_pkg
module wavp_parse (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  output wavp_pkg::res_t res
);

  logic [5:0]        pos_r, pos_nxt;
  logic              riff_r, riff_nxt;
  logic              wave_r, wave_nxt;
  logic [15:0]       chan_r, chan_nxt;
  logic [31:0]       rate_r, rate_nxt;
  logic [15:0]       depth_r, depth_nxt;
  logic [31:0]       size_r, size_nxt;
  logic [7:0]        low_r, low_nxt;
  logic              low_vld_r, low_vld_nxt;
  wavp_pkg::phase_t  phase_r, phase_nxt;

  always_comb begin
    pos_nxt     = pos_r;
    riff_nxt    = riff_r;
    wave_nxt    = wave_r;
    chan_nxt    = chan_r;
    rate_nxt    = rate_r;
    depth_nxt   = depth_r;
    size_nxt    = size_r;
    low_nxt     = low_r;
    low_vld_nxt = low_vld_r;
    phase_nxt   = phase_r;
    res         = '0;
    res.kind    = wavp_pkg::KIND_HEADER;

    case (phase_r)
      wavp_pkg::PH_HEADER: begin
        if (pos_r < 6'(wavp_pkg::RIFF_POS + 4) &&
            data_byte != wavp_pkg::tag_byte(wavp_pkg::RIFF_TAG,
                                            2'(pos_r - 6'(wavp_pkg::RIFF_POS)))) begin
          riff_nxt = 1'b0;
        end
        if (pos_r >= 6'(wavp_pkg::WAVE_POS) && pos_r < 6'(wavp_pkg::WAVE_POS + 4) &&
            data_byte != wavp_pkg::tag_byte(wavp_pkg::WAVE_TAG,
                                            2'(pos_r - 6'(wavp_pkg::WAVE_POS)))) begin
          wave_nxt = 1'b0;
        end
        if (pos_r >= 6'(wavp_pkg::CHAN_POS) && pos_r < 6'(wavp_pkg::CHAN_POS + 2)) begin
          chan_nxt = 16'(wavp_pkg::put_lane({16'h0, chan_r}, data_byte,
                                            2'(pos_r - 6'(wavp_pkg::CHAN_POS))));
        end
        if (pos_r >= 6'(wavp_pkg::RATE_POS) && pos_r < 6'(wavp_pkg::RATE_POS + 4)) begin
          rate_nxt = wavp_pkg::put_lane(rate_r, data_byte,
                                        2'(pos_r - 6'(wavp_pkg::RATE_POS)));
        end
        if (pos_r >= 6'(wavp_pkg::DEPTH_POS) && pos_r < 6'(wavp_pkg::DEPTH_POS + 2)) begin
          depth_nxt = 16'(wavp_pkg::put_lane({16'h0, depth_r}, data_byte,
                                             2'(pos_r - 6'(wavp_pkg::DEPTH_POS))));
        end
        if (pos_r >= 6'(wavp_pkg::SIZE_POS) && pos_r < 6'(wavp_pkg::SIZE_POS + 4)) begin
          size_nxt = wavp_pkg::put_lane(size_r, data_byte,
                                        2'(pos_r - 6'(wavp_pkg::SIZE_POS)));
        end

        if (pos_r >= 6'(wavp_pkg::HDR_BYTES - 1)) begin
          res.valid = 1'b1;
          res.last  = last_byte;
          if (!riff_nxt) begin
            res.kind  = wavp_pkg::KIND_BAD_RIFF;
            phase_nxt = wavp_pkg::PH_SKIP;
          end else if (!wave_nxt) begin
            res.kind  = wavp_pkg::KIND_BAD_WAVE;
            phase_nxt = wavp_pkg::PH_SKIP;
          end else begin
            res.kind        = wavp_pkg::KIND_HEADER;
            res.channels    = chan_nxt;
            res.sample_rate = rate_nxt;
            res.bit_depth   = depth_nxt;
            res.data_length = size_nxt;
            phase_nxt       = wavp_pkg::PH_SAMPLES;
          end
        end else if (last_byte) begin
          res.valid = 1'b1;
          res.last  = 1'b1;
          res.kind  = wavp_pkg::KIND_SHORT;
        end else begin
          pos_nxt = pos_r + 6'd1;
        end
      end
      wavp_pkg::PH_SAMPLES: begin
        if (low_vld_r) begin
          res.valid   = 1'b1;
          res.last    = last_byte;
          res.kind    = wavp_pkg::KIND_SAMPLE;
          res.sample  = {data_byte, low_r};
          low_vld_nxt = 1'b0;
        end else if (last_byte) begin
          res.valid = 1'b1;
          res.last  = 1'b1;
          res.kind  = wavp_pkg::KIND_END;
        end else begin
          low_nxt     = data_byte;
          low_vld_nxt = 1'b1;
        end
      end
      default: begin
        // skip phase: rest of a bad file is dropped
      end
    endcase

    // end of file puts everything back to the start
    if (last_byte) begin
      pos_nxt     = '0;
      riff_nxt    = 1'b1;
      wave_nxt    = 1'b1;
      chan_nxt    = '0;
      rate_nxt    = '0;
      depth_nxt   = '0;
      size_nxt    = '0;
      low_nxt     = '0;
      low_vld_nxt = 1'b0;
      phase_nxt   = wavp_pkg::PH_HEADER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      riff_r    <= 1'b1;
      wave_r    <= 1'b1;
      chan_r    <= '0;
      rate_r    <= '0;
      depth_r   <= '0;
      size_r    <= '0;
      low_r     <= '0;
      low_vld_r <= 1'b0;
      phase_r   <= wavp_pkg::PH_HEADER;
    end else if (step_en) begin
      pos_r     <= pos_nxt;
      riff_r    <= riff_nxt;
      wave_r    <= wave_nxt;
      chan_r    <= chan_nxt;
      rate_r    <= rate_nxt;
      depth_r   <= depth_nxt;
      size_r    <= size_nxt;
      low_r     <= low_nxt;
      low_vld_r <= low_vld_nxt;
      phase_r   <= phase_nxt;
    end
  end

endmodule

// ----- verif/tb_wav_header_and_pcm16_parser_unit.sv -----
// testbench for wav_header_and_pcm16_parser_unit: drives whole wav files a byte at a time
// depends on wavp_pkg, wavp_in_if / wavp_out_if and the unit itself; self-checking
// against its own parser model, with random idling on both channels
module tb_wav_header_and_pcm16_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // one result word as the unit should present it
  typedef struct {
    wavp_pkg::kind_t    kind;
    logic signed [15:0] sample;
    logic [15:0]        channels;
    logic [31:0]        sample_rate;
    logic [15:0]        bit_depth;
    logic [31:0]        data_length;
    logic               last;
  } wav_result_t;

  // one directed file: header contents, filler for the unused header bytes,
  // a repeating 8-byte payload pattern, total length, and the first result typed in
  typedef struct {
    logic [31:0]     riff;
    logic [31:0]     wave;
    logic [15:0]     ch;
    logic [31:0]     rate;
    logic [15:0]     depth;
    logic [31:0]     size;
    logic [7:0]      fill;
    logic [63:0]     pay;
    int              len;
    wavp_pkg::kind_t want_kind;
    logic            want_last;
  } dir_file_t;

  logic clk;
  logic rst_n;

  wavp_in_if  in_ch ();
  wavp_out_if out_ch ();

  wav_header_and_pcm16_parser_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // directed files; the first result of each is typed in, the rest
  // (payload samples and trailing ends) come from the parser model
  dir_file_t file_table [12] = '{
    // a one-byte file right after reset: too short
    '{wavp_pkg::RIFF_TAG, wavp_pkg::WAVE_TAG, 16'd0, 32'd0, 16'd0, 32'd0, 8'h00, 64'h0, 1,
      wavp_pkg::KIND_SHORT, 1'b1},
    // good magic but one byte short of a header
    '{wavp_pkg::RIFF_TAG, wavp_pkg::WAVE_TAG, 16'd2, 32'd44100, 16'd16, 32'd1000, 8'hA5,
      64'h0, 43, wavp_pkg::KIND_SHORT, 1'b1},
    // bad magic everywhere, still too short wins
    '{~wavp_pkg::RIFF_TAG, ~wavp_pkg::WAVE_TAG, 16'd2, 32'd44100, 16'd16, 32'd100, 8'hFF,
      64'h0, 12, wavp_pkg::KIND_SHORT, 1'b1},
    // all-ones fields, header byte is also the final byte
    '{wavp_pkg::RIFF_TAG, wavp_pkg::WAVE_TAG, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
      32'hFFFF_FFFF, 8'hFF, 64'h0, 44, wavp_pkg::KIND_HEADER, 1'b1},
    // zero fields, samples at both extremes, even end
    '{wavp_pkg::RIFF_TAG, wavp_pkg::WAVE_TAG, 16'd0, 32'd0, 16'd0, 32'd0, 8'h00,
      64'hFFFF_0000_7FFF_8000, 52, wavp_pkg::KIND_HEADER, 1'b0},
    // odd trailing byte after two samples
    '{wavp_pkg::RIFF_TAG, wavp_pkg::WAVE_TAG, 16'd1, 32'd8000, 16'd8, 32'd36, 8'h5A,
      64'h0123_4567_89AB_CDEF, 49, wavp_pkg::KIND_HEADER, 1'b0},
    // empty data, a lone trailing byte
    '{wavp_pkg::RIFF_TAG, wavp_pkg::WAVE_TAG, 16'd2, 32'd48000, 16'd16, 32'd0, 8'h00,
      64'h0, 45, wavp_pkg::KIND_HEADER, 1'b0},
    // both tags bad: riff reported, rest of the file ignored
    '{~wavp_pkg::RIFF_TAG, wavp_pkg::WAVE_TAG ^ 32'h0000_0001, 16'd1, 32'd1, 16'd1, 32'd1,
      8'h3C, 64'h1122_3344_5566_7788, 48, wavp_pkg::KIND_BAD_RIFF, 1'b0},
    // only the top riff bit off, file ends on the header byte
    '{wavp_pkg::RIFF_TAG ^ 32'h8000_0000, wavp_pkg::WAVE_TAG, 16'd1, 32'd1, 16'd1, 32'd1,
      8'h00, 64'h0, 44, wavp_pkg::KIND_BAD_RIFF, 1'b1},
    // last wave byte off, some ignored payload
    '{wavp_pkg::RIFF_TAG, wavp_pkg::WAVE_TAG ^ 32'h0100_0000, 16'd6, 32'd96000, 16'd24,
      32'd600, 8'hC3, 64'hDEAD_BEEF_CAFE_F00D, 46, wavp_pkg::KIND_BAD_WAVE, 1'b0},
    // first wave byte off, ends on the header byte
    '{wavp_pkg::RIFF_TAG, wavp_pkg::WAVE_TAG ^ 32'h0000_0001, 16'd2, 32'd22050, 16'd16,
      32'd4, 8'h00, 64'h0, 44, wavp_pkg::KIND_BAD_WAVE, 1'b1},
    // single high bits in channels, rate and depth, one sample as an even end
    '{wavp_pkg::RIFF_TAG, wavp_pkg::WAVE_TAG, 16'h8000, 32'h8000_0000, 16'h8000,
      32'h0000_0001, 8'hAA, 64'hAAAA_AAAA_AAAA_AAAA, 46, wavp_pkg::KIND_HEADER, 1'b0}
  };

  // parser model state
  logic [5:0]       hdr_pos;
  bit               riff_seen_ok;
  bit               wave_seen_ok;
  logic [15:0]      chan_acc;
  logic [31:0]      rate_acc;
  logic [15:0]      depth_acc;
  logic [31:0]      size_acc;
  logic [7:0]       low_half;
  bit               low_half_full;
  wavp_pkg::phase_t parse_phase;

  wav_result_t pending_results [$];
  logic [7:0]  file_bytes [$];

  int tx_idle_pct = 11;
  int rx_idle_pct = 55;
  int mismatches  = 0;
  int bytes_sent  = 0;
  int files_sent  = 0;
  int results_seen = 0;
  int kind_seen [8];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40)
      $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  // back to the start of a file
  task automatic clear_parser();
    hdr_pos       = '0;
    riff_seen_ok  = 1'b1;
    wave_seen_ok  = 1'b1;
    chan_acc      = '0;
    rate_acc      = '0;
    depth_acc     = '0;
    size_acc      = '0;
    low_half      = '0;
    low_half_full = 1'b0;
    parse_phase   = wavp_pkg::PH_HEADER;
  endtask

  // model of one accepted byte; got says whether it yields a result word
  task automatic parse_byte(input logic [7:0] b, input logic lst, output bit got,
                            output wav_result_t r);
    int p;
    got           = 1'b0;
    r.kind        = wavp_pkg::KIND_HEADER;
    r.sample      = '0;
    r.channels    = '0;
    r.sample_rate = '0;
    r.bit_depth   = '0;
    r.data_length = '0;
    r.last        = lst;
    if (parse_phase == wavp_pkg::PH_HEADER) begin
      p = hdr_pos;
      // magic compares, little-endian field capture
      if (p < wavp_pkg::RIFF_POS + 4 &&
          b != wavp_pkg::RIFF_TAG[(p - wavp_pkg::RIFF_POS) * 8 +: 8])
        riff_seen_ok = 1'b0;
      if (p >= wavp_pkg::WAVE_POS && p < wavp_pkg::WAVE_POS + 4 &&
          b != wavp_pkg::WAVE_TAG[(p - wavp_pkg::WAVE_POS) * 8 +: 8])
        wave_seen_ok = 1'b0;
      if (p >= wavp_pkg::CHAN_POS && p < wavp_pkg::CHAN_POS + 2)
        chan_acc[(p - wavp_pkg::CHAN_POS) * 8 +: 8] = b;
      if (p >= wavp_pkg::RATE_POS && p < wavp_pkg::RATE_POS + 4)
        rate_acc[(p - wavp_pkg::RATE_POS) * 8 +: 8] = b;
      if (p >= wavp_pkg::DEPTH_POS && p < wavp_pkg::DEPTH_POS + 2)
        depth_acc[(p - wavp_pkg::DEPTH_POS) * 8 +: 8] = b;
      if (p >= wavp_pkg::SIZE_POS && p < wavp_pkg::SIZE_POS + 4)
        size_acc[(p - wavp_pkg::SIZE_POS) * 8 +: 8] = b;
      if (p + 1 >= wavp_pkg::HDR_BYTES) begin
        // riff is judged before wave
        got = 1'b1;
        if (!riff_seen_ok) begin
          r.kind      = wavp_pkg::KIND_BAD_RIFF;
          parse_phase = wavp_pkg::PH_SKIP;
        end else if (!wave_seen_ok) begin
          r.kind      = wavp_pkg::KIND_BAD_WAVE;
          parse_phase = wavp_pkg::PH_SKIP;
        end else begin
          r.kind        = wavp_pkg::KIND_HEADER;
          r.channels    = chan_acc;
          r.sample_rate = rate_acc;
          r.bit_depth   = depth_acc;
          r.data_length = size_acc;
          parse_phase   = wavp_pkg::PH_SAMPLES;
        end
      end else if (lst) begin
        got    = 1'b1;
        r.kind = wavp_pkg::KIND_SHORT;
      end else begin
        hdr_pos = hdr_pos + 1'b1;
      end
    end else if (parse_phase == wavp_pkg::PH_SAMPLES) begin
      // low byte first; an unpaired final byte is dropped with an end word
      if (low_half_full) begin
        got           = 1'b1;
        r.kind        = wavp_pkg::KIND_SAMPLE;
        r.sample      = {b, low_half};
        low_half_full = 1'b0;
      end else if (lst) begin
        got    = 1'b1;
        r.kind = wavp_pkg::KIND_END;
      end else begin
        low_half      = b;
        low_half_full = 1'b1;
      end
    end
    // skip phase: bad header, nothing until the file ends
    if (lst)
      clear_parser();
  endtask

  // lay out len bytes of a file: header fields over filler, then the payload, or over random bytes
  task automatic build_file(input logic [31:0] riff, input logic [31:0] wave,
                            input logic [15:0] ch, input logic [31:0] rate,
                            input logic [15:0] depth, input logic [31:0] size,
                            input bit rand_bytes, input logic [7:0] fill,
                            input logic [63:0] pay, input int len);
    logic [7:0] v;
    file_bytes.delete();
    for (int i = 0; i < len; i++) begin
      if (rand_bytes)
        v = 8'($urandom);
      else if (i < wavp_pkg::HDR_BYTES)
        v = fill;
      else
        v = pay[((i - wavp_pkg::HDR_BYTES) % 8) * 8 +: 8];
      if (i < wavp_pkg::RIFF_POS + 4)
        v = riff[(i - wavp_pkg::RIFF_POS) * 8 +: 8];
      else if (i >= wavp_pkg::WAVE_POS && i < wavp_pkg::WAVE_POS + 4)
        v = wave[(i - wavp_pkg::WAVE_POS) * 8 +: 8];
      else if (i >= wavp_pkg::CHAN_POS && i < wavp_pkg::CHAN_POS + 2)
        v = ch[(i - wavp_pkg::CHAN_POS) * 8 +: 8];
      else if (i >= wavp_pkg::RATE_POS && i < wavp_pkg::RATE_POS + 4)
        v = rate[(i - wavp_pkg::RATE_POS) * 8 +: 8];
      else if (i >= wavp_pkg::DEPTH_POS && i < wavp_pkg::DEPTH_POS + 2)
        v = depth[(i - wavp_pkg::DEPTH_POS) * 8 +: 8];
      else if (i >= wavp_pkg::SIZE_POS && i < wavp_pkg::SIZE_POS + 4)
        v = size[(i - wavp_pkg::SIZE_POS) * 8 +: 8];
      file_bytes.push_back(v);
    end
  endtask

  // send file_bytes, final byte flagged; the model runs at each accepted word.
  // with typed_on the file's first result is the typed one instead of the model's
  task automatic send_file(input bit typed_on, input wav_result_t typed);
    bit          typed_done;
    bit          got;
    logic        lst;
    wav_result_t r;
    typed_done = 1'b0;
    foreach (file_bytes[i]) begin
      lst = (i == file_bytes.size() - 1);
      // random sender gap before the word
      if ($urandom_range(99) < tx_idle_pct) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      in_ch.valid     <= 1'b1;
      in_ch.data_byte <= file_bytes[i];
      in_ch.last_byte <= lst;
      do @(posedge clk); while (!in_ch.ready);
      parse_byte(file_bytes[i], lst, got, r);
      if (got) begin
        if (typed_on && !typed_done) begin
          pending_results.push_back(typed);
          typed_done = 1'b1;
        end else begin
          pending_results.push_back(r);
        end
      end
      bytes_sent++;
    end
    files_sent++;
  endtask

  // header field value, leaning on the extremes
  function automatic logic [31:0] pick_field();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed files with random content, otherwise short, bad-tag or noise files
  task automatic random_file();
    int          sel;
    int          len;
    logic [31:0] riff;
    logic [31:0] wave;
    wav_result_t unused;
    riff = wavp_pkg::RIFF_TAG;
    wave = wavp_pkg::WAVE_TAG;
    sel  = $urandom_range(99);
    if (sel >= 88) begin
      // raw noise of 1 to 60 bytes
      file_bytes.delete();
      repeat ($urandom_range(1, 60)) file_bytes.push_back(8'($urandom));
    end else begin
      len = (sel >= 60 && sel < 70) ? $urandom_range(1, wavp_pkg::HDR_BYTES - 1)
                                    : wavp_pkg::HDR_BYTES + $urandom_range(20);
      if (sel >= 70 && sel < 80) begin
        riff ^= 32'($urandom_range(1, 255)) << ($urandom_range(3) * 8);
        if ($urandom_range(1))
          wave ^= 32'($urandom_range(1, 255)) << ($urandom_range(3) * 8);
      end else if (sel >= 80) begin
        wave ^= 32'($urandom_range(1, 255)) << ($urandom_range(3) * 8);
      end
      build_file(riff, wave, 16'(pick_field()), pick_field(), 16'(pick_field()),
                 pick_field(), 1'b1, 8'h00, 64'h0, len);
    end
    send_file(1'b0, unused);
  endtask

  task automatic run_random(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget)
      random_file();
  endtask

  // sender holds off until every pending result has come back
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result receiver: random stalls at the current rate
  always @(posedge clk)
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);

  // result checker: each accepted word against the oldest pending one
  always @(posedge clk) begin
    wav_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (!$isunknown(out_ch.kind))
        kind_seen[out_ch.kind]++;
      if (pending_results.size() == 0) begin
        report_mismatch("kind of a result with nothing pending", 32'(out_ch.kind), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.kind !== want.kind)
          report_mismatch("kind", 32'(out_ch.kind), 32'(want.kind));
        if (out_ch.sample !== want.sample)
          report_mismatch("sample", 32'(out_ch.sample), 32'(want.sample));
        if (out_ch.channels !== want.channels)
          report_mismatch("channels", 32'(out_ch.channels), 32'(want.channels));
        if (out_ch.sample_rate !== want.sample_rate)
          report_mismatch("sample_rate", out_ch.sample_rate, want.sample_rate);
        if (out_ch.bit_depth !== want.bit_depth)
          report_mismatch("bit_depth", 32'(out_ch.bit_depth), 32'(want.bit_depth));
        if (out_ch.data_length !== want.data_length)
          report_mismatch("data_length", out_ch.data_length, want.data_length);
        if (out_ch.last !== want.last)
          report_mismatch("last", 32'(out_ch.last), 32'(want.last));
      end
    end
  end

  // hard stop well past the slowest correct run
  initial begin
    #5ms;
    $display("[wav_header_and_pcm16_parser_unit] ERROR");
    $finish;
  end

  initial begin
    dir_file_t   row;
    wav_result_t typed;
    int          guard;
    // known values on every input from time zero
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    clear_parser();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed files, sender idle 11 / receiver idle 55
    foreach (file_table[i]) begin
      row = file_table[i];
      build_file(row.riff, row.wave, row.ch, row.rate, row.depth, row.size, 1'b0,
                 row.fill, row.pay, row.len);
      typed.kind        = row.want_kind;
      typed.sample      = '0;
      typed.channels    = (row.want_kind == wavp_pkg::KIND_HEADER) ? row.ch : '0;
      typed.sample_rate = (row.want_kind == wavp_pkg::KIND_HEADER) ? row.rate : '0;
      typed.bit_depth   = (row.want_kind == wavp_pkg::KIND_HEADER) ? row.depth : '0;
      typed.data_length = (row.want_kind == wavp_pkg::KIND_HEADER) ? row.size : '0;
      typed.last        = row.want_last;
      send_file(1'b1, typed);
    end
    run_random(25);
    hold_until_drained();

    // busy sender / slow receiver swapped
    tx_idle_pct = 55;
    rx_idle_pct = 11;
    run_random(25);
    hold_until_drained();

    // full rate both ways
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(25);
    in_ch.valid <= 1'b0;

    // drain, then wait on for anything stray
    guard = 0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", '0, 32'(pending_results.size()));

    $display("covered %0d files / %0d bytes: %0d headers, %0d samples, %0d short, %0d bad riff,",
             files_sent, bytes_sent, kind_seen[wavp_pkg::KIND_HEADER],
             kind_seen[wavp_pkg::KIND_SAMPLE], kind_seen[wavp_pkg::KIND_SHORT],
             kind_seen[wavp_pkg::KIND_BAD_RIFF]);
    $display("%0d bad wave, %0d odd ends; %0d results checked under three idle mixes",
             kind_seen[wavp_pkg::KIND_BAD_WAVE], kind_seen[wavp_pkg::KIND_END],
             results_seen);
    if (mismatches == 0)
      $display("[wav_header_and_pcm16_parser_unit] OK");
    else
      $display("[wav_header_and_pcm16_parser_unit] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/wavp_pkg.sv
rtl/wavp_if.sv
rtl/wavp_parse.sv
rtl/wav_header_and_pcm16_parser_unit.sv
verif/tb_wav_header_and_pcm16_parser_unit.sv
